>>> rtl/core/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler core.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned DIM_W  = 9;   // configuration register width
  localparam int unsigned FRAC_W = 16;  // fraction bits of mapped position
  localparam int unsigned QUO_W  = 25;  // mapped position: 9 integer + 16 fraction
  localparam int unsigned NUM_W  = 17;  // coordinate times (source size - 1)
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_DEST_W = 3'd2,
    REG_DEST_H = 3'd3
  } cfg_reg_e;

  // fields that travel alongside the mapping arithmetic
  typedef struct packed {
    logic        action;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] pix;
    logic        inr;
  } side_t;

  // neighbour selection and weights from the store stage to the blend stages
  typedef struct packed {
    logic        pxa;
    logic        pya;
    logic        cx;
    logic        cy;
    logic [15:0] fx;
    logic [15:0] fy;
    logic        inr;
  } sel_t;

endpackage

>>> rtl/core/bis_divider.sv
// ----------------------------------------------------------------------------
// bis_divider
// Pipelined restoring divider, one quotient bit per stage, for both axes.
// ----------------------------------------------------------------------------
module bis_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  bis_pkg::side_t                 side_i,
  input  logic [bis_pkg::NUM_W-1:0]      nx_i,
  input  logic [bis_pkg::NUM_W-1:0]      ny_i,
  input  logic [bis_pkg::DIM_W-1:0]      dw_i,
  input  logic [bis_pkg::DIM_W-1:0]      dh_i,
  output logic                           valid_o,
  output bis_pkg::side_t                 side_o,
  output logic [bis_pkg::QUO_W-1:0]      gx_o,
  output logic [bis_pkg::QUO_W-1:0]      gy_o
);

  localparam int unsigned STEPS = bis_pkg::QUO_W;
  localparam int unsigned DW    = bis_pkg::DIM_W;
  localparam int unsigned NW    = bis_pkg::NUM_W;
  localparam int unsigned FW    = bis_pkg::FRAC_W;

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic b,
                                           input logic [DW-1:0] d);
    logic [DW:0] t;
    logic        ge;
    logic [DW-1:0] nr;
    t  = {rem, b};
    ge = (t >= {1'b0, d});
    nr = ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
    return {ge, nr};
  endfunction

  logic [STEPS-1:0]  v_q;
  bis_pkg::side_t    side_q [STEPS];
  logic [DW-1:0]     rx_q   [STEPS];
  logic [DW-1:0]     ry_q   [STEPS];
  logic [NW-1:0]     nx_q   [STEPS];
  logic [NW-1:0]     ny_q   [STEPS];
  logic [STEPS-1:0]  qx_q   [STEPS];
  logic [STEPS-1:0]  qy_q   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    localparam int J = STEPS - 1 - k;
    logic              cv;
    bis_pkg::side_t    cs;
    logic [DW-1:0]     crx, cry;
    logic [NW-1:0]     cnx, cny;
    logic [STEPS-1:0]  cqx, cqy;
    logic              bx, by;
    logic [DW:0]       sx, sy;

    if (k == 0) begin : g_first
      // the dividend top bits seed the remainder
      assign cv  = valid_i;
      assign cs  = side_i;
      assign cnx = nx_i;
      assign cny = ny_i;
      assign crx = {1'b0, nx_i[NW-1:NW-8]};
      assign cry = {1'b0, ny_i[NW-1:NW-8]};
      assign cqx = '0;
      assign cqy = '0;
    end else begin : g_next
      assign cv  = v_q[k-1];
      assign cs  = side_q[k-1];
      assign cnx = nx_q[k-1];
      assign cny = ny_q[k-1];
      assign crx = rx_q[k-1];
      assign cry = ry_q[k-1];
      assign cqx = qx_q[k-1];
      assign cqy = qy_q[k-1];
    end

    if (J >= FW) begin : g_nbit
      assign bx = cnx[J-FW];
      assign by = cny[J-FW];
    end else begin : g_zbit
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    assign sx = div_step(crx, bx, dw_i);
    assign sy = div_step(cry, by, dh_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[k] <= cs;
        nx_q[k]   <= cnx;
        ny_q[k]   <= cny;
        rx_q[k]   <= sx[DW-1:0];
        ry_q[k]   <= sy[DW-1:0];
        qx_q[k]   <= {cqx[STEPS-2:0], sx[DW]};
        qy_q[k]   <= {cqy[STEPS-2:0], sy[DW]};
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];
  assign gx_o    = qx_q[STEPS-1];
  assign gy_o    = qy_q[STEPS-1];

endmodule

>>> rtl/core/bis_store.sv
// ----------------------------------------------------------------------------
// bis_store
// Source frame store in four banks by column and row parity, so that the
// four neighbours of a sample are read in parallel.
// ----------------------------------------------------------------------------
module bis_store #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  bis_pkg::side_t                 side_i,
  input  logic [bis_pkg::QUO_W-1:0]      gx_i,
  input  logic [bis_pkg::QUO_W-1:0]      gy_i,
  input  logic [bis_pkg::DIM_W-1:0]      swm1_i,
  input  logic [bis_pkg::DIM_W-1:0]      shm1_i,
  output logic                           valid_o,
  output bis_pkg::sel_t                  sel_o,
  output logic [3:0][31:0]               rd_o
);

  localparam int unsigned DW    = bis_pkg::DIM_W;
  localparam int unsigned FW    = bis_pkg::FRAC_W;
  localparam int unsigned CW    = (MAX_DIM > 4) ? $clog2(MAX_DIM) : 2;
  localparam int unsigned HW    = CW - 1;
  localparam int unsigned DEPTH = 2 ** (2 * HW);

  typedef logic [HW-1:0]   half_t;
  typedef logic [2*HW-1:0] addr_t;

  logic [DW-1:0] xi_raw, yi_raw, xi, yi;
  logic [DW:0]   xp1, yp1;
  logic          cx, cy;
  half_t         col_a [2];
  half_t         row_a [2];
  addr_t         raddr [4];
  addr_t         waddr;
  logic [1:0]    wbank;
  logic          load_ok, we;

  logic          valid_q;
  bis_pkg::sel_t sel_q;
  logic [31:0]   rd_q [4];

  always_comb begin
    xi_raw = gx_i[bis_pkg::QUO_W-1:FW];
    yi_raw = gy_i[bis_pkg::QUO_W-1:FW];
    xi     = (xi_raw > swm1_i) ? swm1_i : xi_raw;
    yi     = (yi_raw > shm1_i) ? shm1_i : yi_raw;
    // right and lower neighbour fall back onto the last column and row
    cx     = (xi >= swm1_i);
    cy     = (yi >= shm1_i);
    xp1    = {1'b0, xi} + 1'b1;
    yp1    = {1'b0, yi} + 1'b1;
    for (int p = 0; p < 2; p++) begin
      col_a[p] = (xi[0] == 1'(p)) ? half_t'(xi >> 1) : half_t'(xp1 >> 1);
      row_a[p] = (yi[0] == 1'(p)) ? half_t'(yi >> 1) : half_t'(yp1 >> 1);
    end
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {row_a[b/2], col_a[b%2]};
    end
    load_ok = (32'(side_i.x) < MAX_DIM) && (32'(side_i.y) < MAX_DIM);
    we      = adv_i && valid_i && (side_i.action == bis_pkg::ACT_LOAD) && load_ok;
    wbank   = {side_i.y[0], side_i.x[0]};
    waddr   = {half_t'(side_i.y >> 1), half_t'(side_i.x >> 1)};
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] mem [DEPTH];
    always_ff @(posedge clk_i) begin
      if (we && (wbank == 2'(b))) begin
        mem[waddr] <= side_i.pix;
      end
      if (adv_i) begin
        rd_q[b] <= mem[raddr[b]];
      end
    end
    assign rd_o[b] = rd_q[b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i && (side_i.action == bis_pkg::ACT_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sel_q.pxa <= xi[0];
      sel_q.pya <= yi[0];
      sel_q.cx  <= cx;
      sel_q.cy  <= cy;
      sel_q.fx  <= gx_i[FW-1:0];
      sel_q.fy  <= gy_i[FW-1:0];
      sel_q.inr <= side_i.inr;
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

>>> rtl/core/bis_blend.sv
// ----------------------------------------------------------------------------
// bis_blend
// Three-stage bilinear blend of four neighbours, per byte channel.
// ----------------------------------------------------------------------------
module bis_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  bis_pkg::sel_t     sel_i,
  input  logic [3:0][31:0]  rd_i,
  output logic              valid_o,
  output logic [31:0]       pixel_out_o,
  output logic              in_range_o
);

  logic [16:0] wx, wy1;
  logic        nxp, nyp;
  logic [31:0] c00, c10, c01, c11;
  logic [23:0] top_d [4];
  logic [23:0] bot_d [4];
  logic [40:0] pt_d  [4];
  logic [40:0] pb_d  [4];
  logic [31:0] pix_d;

  logic        v1_q, v2_q, v3_q;
  logic [23:0] top_q [4];
  logic [23:0] bot_q [4];
  logic [15:0] fy1_q;
  logic        inr1_q, inr2_q;
  logic [40:0] pt_q  [4];
  logic [40:0] pb_q  [4];
  logic [31:0] pix_q;
  logic        inr3_q;

  always_comb begin
    logic [41:0] s;
    logic [9:0]  v;
    nxp = sel_i.cx ? sel_i.pxa : ~sel_i.pxa;
    nyp = sel_i.cy ? sel_i.pya : ~sel_i.pya;
    c00 = rd_i[{sel_i.pya, sel_i.pxa}];
    c10 = rd_i[{sel_i.pya, nxp}];
    c01 = rd_i[{nyp, sel_i.pxa}];
    c11 = rd_i[{nyp, nxp}];
    wx  = 17'h10000 - {1'b0, sel_i.fx};
    wy1 = 17'h10000 - {1'b0, fy1_q};
    pix_d = '0;
    for (int ch = 0; ch < 4; ch++) begin
      top_d[ch] = 24'(25'(c00[8*ch +: 8]) * 25'(wx) + 25'(c10[8*ch +: 8]) * 25'(sel_i.fx));
      bot_d[ch] = 24'(25'(c01[8*ch +: 8]) * 25'(wx) + 25'(c11[8*ch +: 8]) * 25'(sel_i.fx));
      pt_d[ch]  = 41'(top_q[ch]) * 41'(wy1);
      pb_d[ch]  = 41'(bot_q[ch]) * 41'(fy1_q);
      s = 42'(pt_q[ch]) + 42'(pb_q[ch]);
      v = s[41:32];
      pix_d[8*ch +: 8] = (v > 10'h0FF) ? 8'hFF : v[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      fy1_q  <= sel_i.fy;
      inr1_q <= sel_i.inr;
      pt_q   <= pt_d;
      pb_q   <= pb_d;
      inr2_q <= inr1_q;
      // out-of-range requests give a zero pixel
      pix_q  <= inr2_q ? pix_d : 32'h0;
      inr3_q <= inr2_q;
    end
  end

  assign valid_o     = v3_q;
  assign pixel_out_o = pix_q;
  assign in_range_o  = inr3_q;

endmodule

>>> rtl/core/bilinear_image_scaler_core.sv
// A sample request passes the input register, the 25-stage bit-per-stage
// coordinate divider, the frame store read register and the blend stages.
// Throughput: one request per cycle; the pipeline holds as a whole when the
// output is stalled.
// Loads are written into the four-bank frame store at the read stage.
// Reset clears valid bits and sets all four size registers to 256.
// ----------------------------------------------------------------------------
// bilinear_image_scaler_core
// Bilinear RGBA image scaler with source frame store and size registers.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_core #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bis_pkg::DIM_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [7:0]                       coord_x_i,
  input  logic [7:0]                       coord_y_i,
  input  logic [31:0]                      pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      pixel_out_o,
  output logic                             in_range_o
);

  localparam int unsigned DW      = bis_pkg::DIM_W;
  localparam int unsigned NW      = bis_pkg::NUM_W;
  localparam int unsigned DIM_CAP = (MAX_DIM > 511) ? 511 : MAX_DIM;

  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (32'(v) > DIM_CAP) begin
      return DW'(DIM_CAP);
    end
    return v;
  endfunction

  logic [DW-1:0] src_w_q, src_h_q, dest_w_q, dest_h_q;
  logic [DW-1:0] sw, sh, dw, dh, swm1, shm1;
  logic          adv;

  logic           s1_v_q;
  bis_pkg::side_t s1_side_q;
  logic [NW-1:0]  s1_nx_q, s1_ny_q;
  bis_pkg::side_t in_side;

  logic                        dv_v;
  bis_pkg::side_t              dv_side;
  logic [bis_pkg::QUO_W-1:0]   gx, gy;
  logic                        st_v;
  bis_pkg::sel_t               st_sel;
  logic [3:0][31:0]            st_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= 9'd256;
      src_h_q  <= 9'd256;
      dest_w_q <= 9'd256;
      dest_h_q <= 9'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bis_pkg::REG_SRC_W:  src_w_q  <= cfg_data_i;
        bis_pkg::REG_SRC_H:  src_h_q  <= cfg_data_i;
        bis_pkg::REG_DEST_W: dest_w_q <= cfg_data_i;
        bis_pkg::REG_DEST_H: dest_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw   = eff_dim(src_w_q);
  assign sh   = eff_dim(src_h_q);
  assign dw   = eff_dim(dest_w_q);
  assign dh   = eff_dim(dest_h_q);
  assign swm1 = sw - 1'b1;
  assign shm1 = sh - 1'b1;

  // the whole pipeline holds while a finished result waits
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    in_side.action = action_i;
    in_side.x      = coord_x_i;
    in_side.y      = coord_y_i;
    in_side.pix    = pixel_in_i;
    in_side.inr    = ({1'b0, coord_x_i} < dw) && ({1'b0, coord_y_i} < dh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q <= in_side;
      s1_nx_q   <= NW'(coord_x_i) * NW'(swm1);
      s1_ny_q   <= NW'(coord_y_i) * NW'(shm1);
    end
  end

  bis_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_v_q),
    .side_i  (s1_side_q),
    .nx_i    (s1_nx_q),
    .ny_i    (s1_ny_q),
    .dw_i    (dw),
    .dh_i    (dh),
    .valid_o (dv_v),
    .side_o  (dv_side),
    .gx_o    (gx),
    .gy_o    (gy)
  );

  bis_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_v),
    .side_i  (dv_side),
    .gx_i    (gx),
    .gy_i    (gy),
    .swm1_i  (swm1),
    .shm1_i  (shm1),
    .valid_o (st_v),
    .sel_o   (st_sel),
    .rd_o    (st_rd)
  );

  bis_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (st_v),
    .sel_i       (st_sel),
    .rd_i        (st_rd),
    .valid_o     (out_valid_o),
    .pixel_out_o (pixel_out_o),
    .in_range_o  (in_range_o)
  );

endmodule

>>> test/bis_scaler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bis_scaler_checker
// Watches the config, request and result channels of the scaler, keeps its
// own copy of the frame store and size registers, and compares each result.
// ----------------------------------------------------------------------------
module bis_scaler_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bis_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          action_i,
  input  logic [7:0]                    coord_x_i,
  input  logic [7:0]                    coord_y_i,
  input  logic [31:0]                   pixel_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [31:0]                   pixel_out_i,
  input  logic                          in_range_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [31:0] pix;
    logic        inr;
  } scaled_pix_t;

  logic [31:0]              frame_mem [0:65535];
  logic [bis_pkg::DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  scaled_pix_t              expected_pix_q [$];

  assign pending_o = expected_pix_q.size();

  function automatic int unsigned clamp_dim(logic [bis_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > 9'd256) return 256;
    return 32'(v);
  endfunction

  function automatic logic [31:0] pix_at(int unsigned x, int unsigned y);
    return frame_mem[16'(y * 256 + x)];
  endfunction

  function automatic scaled_pix_t scale_pixel(logic [7:0] x, logic [7:0] y);
    scaled_pix_t       res;
    int unsigned       sw, sh, dw, dh, xi, yi, xn, yn;
    longint unsigned   gx, gy, fx, fy, a, b, c, d, top, bot, v;
    logic [31:0]       c00, c10, c01, c11;
    sw = clamp_dim(src_w_q);
    sh = clamp_dim(src_h_q);
    dw = clamp_dim(dst_w_q);
    dh = clamp_dim(dst_h_q);
    res = '0;
    if (32'(x) >= dw || 32'(y) >= dh) return res;
    gx = ((64'(x) * 64'(sw - 1)) << bis_pkg::FRAC_W) / 64'(dw);
    gy = ((64'(y) * 64'(sh - 1)) << bis_pkg::FRAC_W) / 64'(dh);
    xi = 32'(gx >> bis_pkg::FRAC_W);
    yi = 32'(gy >> bis_pkg::FRAC_W);
    fx = gx & 64'hFFFF;
    fy = gy & 64'hFFFF;
    if (xi > sw - 1) xi = sw - 1;
    if (yi > sh - 1) yi = sh - 1;
    xn = (xi + 1 > sw - 1) ? sw - 1 : xi + 1;
    yn = (yi + 1 > sh - 1) ? sh - 1 : yi + 1;
    c00 = pix_at(xi, yi);
    c10 = pix_at(xn, yi);
    c01 = pix_at(xi, yn);
    c11 = pix_at(xn, yn);
    for (int i = 0; i < 4; i++) begin
      a = 64'(c00[8*i +: 8]);
      b = 64'(c10[8*i +: 8]);
      c = 64'(c01[8*i +: 8]);
      d = 64'(c11[8*i +: 8]);
      top = a * (64'd65536 - fx) + b * fx;
      bot = c * (64'd65536 - fx) + d * fx;
      v = (top * (64'd65536 - fy) + bot * fy) >> 32;
      if (v > 64'd255) v = 64'd255;
      res.pix[8*i +: 8] = v[7:0];
    end
    res.inr = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scaled_pix_t want;
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 9'd256;
      dst_h_q <= 9'd256;
      fail_count_o <= 0;
      expected_pix_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pix_q.size() == 0) begin
          $display("%0t: result with no request waiting: pixel_out %h in_range %b",
                   $time, pixel_out_i, in_range_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_pix_q.pop_front();
          if (pixel_out_i !== want.pix || in_range_i !== want.inr) begin
            $display("%0t: mismatch: expected pixel_out %h in_range %b, got %h %b",
                     $time, want.pix, want.inr, pixel_out_i, in_range_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == bis_pkg::ACT_LOAD) frame_mem[{coord_y_i, coord_x_i}] = pixel_in_i;
        else expected_pix_q.push_back(scale_pixel(coord_x_i, coord_y_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (bis_pkg::cfg_reg_e'(cfg_index_i))
          bis_pkg::REG_SRC_W:  src_w_q <= cfg_data_i;
          bis_pkg::REG_SRC_H:  src_h_q <= cfg_data_i;
          bis_pkg::REG_DEST_W: dst_w_q <= cfg_data_i;
          bis_pkg::REG_DEST_H: dst_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> test/tb_bilinear_image_scaler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_image_scaler_core
// Loads source frames, samples scaled pixels under several size settings and
// random idle/stall patterns; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_bilinear_image_scaler_core;

  logic                          clk_i, rst_ni;
  logic                          cfg_valid_i, cfg_ready_o;
  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bis_pkg::DIM_W-1:0]     cfg_data_i;
  logic                          in_valid_i, in_stall_o;
  logic                          action_i;
  logic [7:0]                    coord_x_i, coord_y_i;
  logic [31:0]                   pixel_in_i;
  logic                          out_valid_o, out_stall_i;
  logic [31:0]                   pixel_out_o;
  logic                          in_range_o;
  int                            fail_count, pending;
  int                            idle_pct, stall_pct;
  int                            request_count;

  bilinear_image_scaler_core i_dut (.*);

  bis_scaler_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .coord_x_i,
    .coord_y_i, .pixel_in_i, .out_valid_i(out_valid_o), .out_stall_i,
    .pixel_out_i(pixel_out_o), .in_range_i(in_range_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("bilinear_image_scaler_core regression: fail");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic send_request(logic act, int unsigned x, int unsigned y, logic [31:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    coord_x_i  <= 8'(x);
    coord_y_i  <= 8'(y);
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    request_count++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(bis_pkg::cfg_reg_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[bis_pkg::DIM_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drain, let the pipeline settle, then set all four sizes
  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (35) @(negedge clk_i);
    write_reg(bis_pkg::REG_SRC_W, sw);
    write_reg(bis_pkg::REG_SRC_H, sh);
    write_reg(bis_pkg::REG_DEST_W, dw);
    write_reg(bis_pkg::REG_DEST_H, dh);
  endtask

  task automatic load_frame(int unsigned sw, int unsigned sh);
    for (int y = 0; y < clamp_dim(sh); y++)
      for (int x = 0; x < clamp_dim(sw); x++)
        send_request(bis_pkg::ACT_LOAD, x, y, $urandom());
  endtask

  // samples mostly within or just past the destination size, with overwrites of the frame mixed in
  task automatic run_samples(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh, int n);
    int unsigned xmax, ymax;
    xmax = (clamp_dim(dw) + 2 > 255) ? 255 : clamp_dim(dw) + 2;
    ymax = (clamp_dim(dh) + 2 > 255) ? 255 : clamp_dim(dh) + 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0)
        send_request(bis_pkg::ACT_LOAD, $urandom_range(clamp_dim(sw) - 1),
                     $urandom_range(clamp_dim(sh) - 1), $urandom());
      else if ($urandom_range(9) == 0)
        send_request(bis_pkg::ACT_SAMPLE, $urandom_range(255), $urandom_range(255),
                     $urandom());
      else
        send_request(bis_pkg::ACT_SAMPLE, $urandom_range(xmax), $urandom_range(ymax),
                     $urandom());
    end
  endtask

  task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh, int n);
    set_sizes(sw, sh, dw, dh);
    load_frame(sw, sh);
    run_samples(sw, sh, dw, dh, n);
  endtask

  initial begin
    int phase;
    int unsigned sw, sh, dw, dh;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bis_pkg::REG_SRC_W;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = bis_pkg::ACT_LOAD;
    coord_x_i   = '0;
    coord_y_i   = '0;
    pixel_in_i  = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    request_count = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: 4x3 source to 8x6 with extreme pixels, corners, outside samples
    set_sizes(4, 3, 8, 6);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++)
        send_request(bis_pkg::ACT_LOAD, x, y, (x + y) % 2 ? 32'hFFFF_FFFF : 32'h0);
    send_request(bis_pkg::ACT_SAMPLE, 0, 0, 32'hFFFF_FFFF);
    send_request(bis_pkg::ACT_SAMPLE, 7, 5, 32'h0);
    send_request(bis_pkg::ACT_SAMPLE, 3, 2, 32'h0);
    send_request(bis_pkg::ACT_SAMPLE, 8, 0, 32'h0);
    send_request(bis_pkg::ACT_SAMPLE, 0, 6, 32'h0);
    send_request(bis_pkg::ACT_SAMPLE, 255, 255, 32'h0);
    send_request(bis_pkg::ACT_LOAD, 255, 255, 32'hA5A5_5A5A);

    // size extremes, including zero and oversized register values
    run_phase(0, 0, 1, 1, 10);
    run_phase(256, 2, 256, 3, 40);
    idle_pct = 59;
    run_phase(2, 256, 3, 256, 40);
    stall_pct = 59;
    idle_pct  = 0;
    run_phase(300, 1, 511, 0, 40);

    phase = 0;
    while (request_count < 1650) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
      dw = ($urandom_range(5) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 40);
      dh = ($urandom_range(5) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 40);
      if ($urandom_range(7) == 0) sw = 0;
      if ($urandom_range(7) == 0) dh = $urandom_range(257, 511);
      run_phase(sw, sh, dw, dh, 60);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0)
      $display("bilinear_image_scaler_core regression: pass");
    else
      $display("bilinear_image_scaler_core regression: fail");
    $finish;
  end

endmodule
